### rtl/core/sorted_table_replace_and_range_count_defines.svh
`ifndef SORTED_TABLE_REPLACE_AND_RANGE_COUNT_DEFINES_SVH
`define SORTED_TABLE_REPLACE_AND_RANGE_COUNT_DEFINES_SVH

// same-cycle implication, clocked on clk and quiet during rst
`define STRC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk and quiet during rst
`define STRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/strc_pkg.sv
package strc_pkg;

  // table geometry
  localparam int CAPACITY    = 1024;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LANES       = (CAPACITY < 32) ? CAPACITY : 32;
  localparam int NUM_GROUPS  = (CAPACITY + LANES - 1) / LANES;
  localparam int GRP_W       = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int PAD         = NUM_GROUPS * LANES;
  localparam int LANE_CW     = $clog2(LANES + 1);
  localparam int FIELD_CNT_W = 11;

  // request kinds
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_REPLACE = 2'd1;
  localparam logic [1:0] KIND_COUNT   = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic signed [31:0] upper;
  } req_t;

  typedef struct packed {
    logic [FIELD_CNT_W-1:0] count;
    logic                   appended;
    logic [FIELD_CNT_W-1:0] table_size;
    logic                   overflow;
  } rsp_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               shift;
    logic               write;
    logic [IDX_W-1:0]   pos;
    logic [CNT_W-1:0]   fill;
    logic signed [31:0] key;
    logic signed [31:0] hi_key;
  } cell_ctl_t;

  typedef struct packed {
    logic lt;
    logic le;
    logic le_hi;
  } cell_flags_t;

  typedef struct packed {
    logic [CNT_W-1:0] n_lt;
    logic [CNT_W-1:0] n_le;
    logic [CNT_W-1:0] n_hi;
  } tally_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

endpackage

### rtl/core/strc_cell.sv
module strc_cell (
  input  logic                      clk,
  input  logic [strc_pkg::IDX_W-1:0] idx,
  input  strc_pkg::cell_ctl_t       ctl,
  input  logic signed [31:0]        left,
  output logic signed [31:0]        entry,
  output strc_pkg::cell_flags_t     flags
);
  import strc_pkg::*;

  logic [CNT_W-1:0] idx_ext;
  logic             valid;

  // a cell holds a live entry when it sits below the fill level
  assign idx_ext = CNT_W'(idx);
  assign valid   = idx_ext < ctl.fill;

  // compare flags against the broadcast bounds
  assign flags.lt    = valid && (entry < ctl.key);
  assign flags.le    = valid && (entry <= ctl.key);
  assign flags.le_hi = valid && (entry <= ctl.hi_key);

  // shift up from the left neighbour above the insert point, or take the key
  always_ff @(posedge clk) begin
    if (ctl.shift && (idx > ctl.pos) && (idx_ext <= ctl.fill)) begin
      entry <= left;
    end else if ((ctl.shift || ctl.write) && (idx == ctl.pos)) begin
      entry <= ctl.key;
    end
  end

endmodule

### rtl/core/strc_tally.sv
module strc_tally (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [strc_pkg::PAD-1:0] lt_vec,
  input  logic [strc_pkg::PAD-1:0] le_vec,
  input  logic [strc_pkg::PAD-1:0] hi_vec,
  output logic                    last,
  output strc_pkg::tally_t        sums
);
  import strc_pkg::*;

  logic             busy;
  logic [GRP_W-1:0] grp;
  logic [LANE_CW-1:0] pc_lt;
  logic [LANE_CW-1:0] pc_le;
  logic [LANE_CW-1:0] pc_hi;

  function automatic logic [LANE_CW-1:0] popcnt(input logic [LANES-1:0] bits);
    logic [LANE_CW-1:0] acc;
    acc = '0;
    for (int i = 0; i < LANES; i++) begin
      acc = acc + LANE_CW'(bits[i]);
    end
    return acc;
  endfunction

  // one group of lanes per cycle
  assign pc_lt = popcnt(lt_vec[grp*LANES +: LANES]);
  assign pc_le = popcnt(le_vec[grp*LANES +: LANES]);
  assign pc_hi = popcnt(hi_vec[grp*LANES +: LANES]);

  assign last = busy && (grp == GRP_W'(NUM_GROUPS - 1));

  // sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (last) begin
      busy <= 1'b0;
    end
  end

  // group pointer and running sums
  always_ff @(posedge clk) begin
    if (start) begin
      grp  <= '0;
      sums <= '0;
    end else if (busy) begin
      grp       <= grp + GRP_W'(1);
      sums.n_lt <= sums.n_lt + CNT_W'(pc_lt);
      sums.n_le <= sums.n_le + CNT_W'(pc_le);
      sums.n_hi <= sums.n_hi + CNT_W'(pc_hi);
    end
  end

endmodule

### rtl/core/sorted_table_replace_and_range_count.sv
// channel | signals                    | direction
// request | req_valid, req_ready, req  | in
// result  | rsp_valid, rsp_ready, rsp  | out
//
// a request is handled in steps: capture, a compare sweep over the cell row
// one group of 32 cells at a time, then a final step that updates the cell
// row and loads the result register.
// reset clears the fill level and the handshakes; cell contents are not cleared.
// a held result does not block capture and sweep of the next request; only
// the final update waits for the result register to free up.
module sorted_table_replace_and_range_count (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  strc_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output strc_pkg::rsp_t  rsp
);
  import strc_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [1:0]         kind_q;
  logic signed [31:0] key_q;
  logic signed [31:0] hi_q;
  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   fill_next;

  logic        accept;
  logic        slot_free;
  logic        finish_go;
  logic        last;
  tally_t      sums;
  cell_ctl_t   ctl;
  logic        do_shift;
  logic        do_write;
  logic [IDX_W-1:0] pos;
  logic        grow;
  logic        ovf;
  logic [CNT_W-1:0] res_count;
  logic        full;

  logic signed [31:0] entries [CAPACITY];
  cell_flags_t        cflags  [CAPACITY];
  logic [PAD-1:0]     lt_vec;
  logic [PAD-1:0]     le_vec;
  logic [PAD-1:0]     hi_vec;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign slot_free = !rsp_valid || rsp_ready;
  assign finish_go = (state == ST_FINISH) && slot_free;
  assign full      = (fill == CNT_W'(CAPACITY));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_SWEEP;
      ST_SWEEP:  if (last) state_next = ST_FINISH;
      ST_FINISH: if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // update decision from the sweep totals
  always_comb begin
    do_shift  = 1'b0;
    do_write  = 1'b0;
    pos       = '0;
    grow      = 1'b0;
    ovf       = 1'b0;
    res_count = '0;
    case (kind_q)
      KIND_LOAD: begin
        if (full) begin
          ovf = 1'b1;
        end else begin
          do_shift = 1'b1;
          pos      = IDX_W'(sums.n_le);
          grow     = 1'b1;
        end
      end
      KIND_REPLACE: begin
        // absent when no entry equals the key
        if (sums.n_le == sums.n_lt) begin
          if (sums.n_lt < fill) begin
            do_write = 1'b1;
            pos      = IDX_W'(sums.n_lt);
          end else if (full) begin
            ovf = 1'b1;
          end else begin
            do_write = 1'b1;
            pos      = IDX_W'(sums.n_lt);
            grow     = 1'b1;
          end
        end
      end
      KIND_COUNT: begin
        if (key_q <= hi_q) begin
          res_count = sums.n_hi - sums.n_lt;
        end
      end
      default: begin
      end
    endcase
    fill_next = fill + CNT_W'(grow);
  end

  // broadcast to the cell row
  assign ctl.shift  = finish_go && do_shift;
  assign ctl.write  = finish_go && do_write;
  assign ctl.pos    = pos;
  assign ctl.fill   = fill;
  assign ctl.key    = key_q;
  assign ctl.hi_key = hi_q;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish_go) begin
        fill      <= fill_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= req.kind;
      key_q  <= req.value;
      hi_q   <= req.upper;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (finish_go) begin
      rsp.count      <= FIELD_CNT_W'(res_count);
      rsp.appended   <= grow;
      rsp.table_size <= FIELD_CNT_W'(fill_next);
      rsp.overflow   <= ovf;
    end
  end

  // row of cells, each fed by its left neighbour, the first by the captured key
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      strc_cell u_cell (
        .clk   (clk),
        .idx   (IDX_W'(i)),
        .ctl   (ctl),
        .left  (key_q),
        .entry (entries[i]),
        .flags (cflags[i])
      );
    end else begin : g_body
      strc_cell u_cell (
        .clk   (clk),
        .idx   (IDX_W'(i)),
        .ctl   (ctl),
        .left  (entries[i-1]),
        .entry (entries[i]),
        .flags (cflags[i])
      );
    end
    assign lt_vec[i] = cflags[i].lt;
    assign le_vec[i] = cflags[i].le;
    assign hi_vec[i] = cflags[i].le_hi;
  end

  // padding lanes of the last group never count
  for (genvar j = CAPACITY; j < PAD; j++) begin : g_pad
    assign lt_vec[j] = 1'b0;
    assign le_vec[j] = 1'b0;
    assign hi_vec[j] = 1'b0;
  end

  strc_tally u_tally (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .lt_vec (lt_vec),
    .le_vec (le_vec),
    .hi_vec (hi_vec),
    .last   (last),
    .sums   (sums)
  );

endmodule

### rtl/core/strc_checker.sv
`include "sorted_table_replace_and_range_count_defines.svh"

module strc_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input strc_pkg::rsp_t rsp
);
  import strc_pkg::*;

  logic [1:0]             pending;
  logic [FIELD_CNT_W-1:0] last_size;
  logic                   req_fire;
  logic                   rsp_fire;
  logic                   rsp_stall;
  logic                   grow_ok;
  logic                   size_ok;

  assign req_fire  = req_valid && req_ready;
  assign rsp_fire  = rsp_valid && rsp_ready;
  assign rsp_stall = rsp_valid && !rsp_ready;

  // an append never comes with a refusal or an empty table
  assign grow_ok = !rsp.overflow && (rsp.table_size != '0);

  // size follows the last reported one plus any append
  assign size_ok = rsp.table_size == last_size + FIELD_CNT_W'(rsp.appended);

  // requests in flight and last reported size
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      last_size <= '0;
    end else begin
      pending <= pending + 2'(req_fire) - 2'(rsp_fire);
      if (rsp_fire) begin
        last_size <= rsp.table_size;
      end
    end
  end

  // stalled result holds
  `STRC_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp), "stalled result moved")

  // no result without a request behind it
  `STRC_ASSERT_SAME(a_rsp_owed, rsp_valid, pending != 2'd0, "result with no request")

  // growth and refusal exclude each other
  `STRC_ASSERT_SAME(a_grow_flag, rsp_valid && rsp.appended, grow_ok, "bad appended flag")

  // size moves only by an append
  `STRC_ASSERT_SAME(a_size_step, rsp_fire, size_ok, "table size jumped")

endmodule

bind sorted_table_replace_and_range_count strc_checker u_strc_checker (.*);

### dv/sorted_table_replace_and_range_count_checker.sv
`timescale 1ns / 1ps

module sorted_table_replace_and_range_count_checker
  import strc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  rsp_t        rsp,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned entries_held,
  output int unsigned refusals
);

  // shadow copy of the table, ascending, duplicates allowed
  logic signed [31:0] held_vals [CAPACITY];
  int unsigned        n_entries = 0;

  // results predicted for accepted requests, oldest first
  rsp_t               outcomes_due [$];

  initial begin
    mismatches   = 0;
    pending      = 0;
    entries_held = 0;
    refusals     = 0;
  end

  // first index holding a value above key (above) or at least key (otherwise)
  function automatic int unsigned first_index(logic signed [31:0] key, bit above);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = n_entries;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (above ? (held_vals[mid] <= key) : (held_vals[mid] < key)) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  // applies one request to the shadow table and returns the result it gives
  function automatic rsp_t table_outcome(input req_t r);
    rsp_t               o;
    int                 pos;
    int                 stop;
    int                 i;
    logic signed [31:0] lo_b;
    logic signed [31:0] hi_b;
    o    = '0;
    lo_b = r.value;
    hi_b = r.upper;
    case (r.kind)
      KIND_LOAD: begin
        if (n_entries >= CAPACITY) begin
          o.overflow = 1'b1;
        end else begin
          // insert after any equal entries
          pos = first_index(lo_b, 1'b1);
          for (i = n_entries; i > pos; i--) held_vals[i] = held_vals[i-1];
          held_vals[pos] = lo_b;
          n_entries++;
          o.appended = 1'b1;
        end
      end
      KIND_REPLACE: begin
        pos = first_index(lo_b, 1'b0);
        if (pos < n_entries && held_vals[pos] == lo_b) begin
          // already present: nothing changes
        end else if (pos < n_entries) begin
          held_vals[pos] = lo_b;
        end else if (n_entries >= CAPACITY) begin
          o.overflow = 1'b1;
        end else begin
          held_vals[n_entries] = lo_b;
          n_entries++;
          o.appended = 1'b1;
        end
      end
      KIND_COUNT: begin
        if (lo_b <= hi_b) begin
          pos     = first_index(lo_b, 1'b0);
          stop    = first_index(hi_b, 1'b1);
          o.count = FIELD_CNT_W'(stop - pos);
        end
      end
      default: begin
      end
    endcase
    o.table_size = FIELD_CNT_W'(n_entries);
    return o;
  endfunction

  // counts a failure, reporting only the first few
  task automatic flag_failure(input string what);
    if (mismatches < 10) $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) outcomes_due.push_back(table_outcome(req));
      if (rsp_valid && rsp_ready) begin
        if (rsp.overflow === 1'b1) refusals++;
        if (outcomes_due.size() == 0) begin
          flag_failure($sformatf("result with nothing expected: count %0d appended %0b size %0d overflow %0b",
                                 rsp.count, rsp.appended, rsp.table_size, rsp.overflow));
        end else begin
          want = outcomes_due.pop_front();
          if (rsp.count !== want.count || rsp.appended !== want.appended ||
              rsp.table_size !== want.table_size || rsp.overflow !== want.overflow) begin
            flag_failure($sformatf({"expected count %0d appended %0b size %0d overflow %0b, ",
                                    "got count %0d appended %0b size %0d overflow %0b"},
                                   want.count, want.appended, want.table_size, want.overflow,
                                   rsp.count, rsp.appended, rsp.table_size, rsp.overflow));
          end
        end
      end
    end
    pending      = outcomes_due.size();
    entries_held = n_entries;
  end

endmodule

### dv/sorted_table_replace_and_range_count_tb.sv
`timescale 1ns / 1ps

module sorted_table_replace_and_range_count_tb;
  import strc_pkg::*;

  localparam logic [1:0]         KIND_UNUSED  = 2'd3;
  localparam int unsigned        CYCLE_LIMIT  = 1000000;
  localparam int unsigned        DRAIN_CYCLES = 40;
  localparam int unsigned        HOLD_CYCLES  = 400;
  localparam int unsigned        MIX_ITEMS    = 800;
  localparam int unsigned        FULL_ITEMS   = 300;
  localparam logic signed [31:0] S_MIN        = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX        = 32'sh7fff_ffff;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned entries_held;
  int unsigned refusals;

  bit                 no_idle     = 1'b0;
  int unsigned        holds_asked = 0;
  int unsigned        cycles      = 0;
  int unsigned        n_load      = 0;
  int unsigned        n_replace   = 0;
  int unsigned        n_count     = 0;
  int unsigned        n_unused    = 0;
  logic signed [31:0] run_val     = 32'sd0;

  sorted_table_replace_and_range_count i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  sorted_table_replace_and_range_count_checker i_monitor (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp          (rsp),
    .mismatches   (mismatches),
    .pending      (pending),
    .entries_held (entries_held),
    .refusals     (refusals)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sorted_table_replace_and_range_count_tb failed");
      $finish;
    end
  end

  // result side: random back-pressure plus long hold-offs on demand
  initial begin : receiver
    int unsigned held_off;
    int unsigned served;
    held_off = 0;
    served   = 0;
    forever begin
      @(negedge clk);
      if (held_off != 0) begin
        rsp_ready <= 1'b0;
        held_off--;
      end else if (holds_asked != served) begin
        served++;
        held_off = HOLD_CYCLES - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= no_idle || ($urandom_range(0, 99) >= 38);
      end
    end
  end

  function automatic logic signed [31:0] clamp_word(longint w);
    if (w > longint'(S_MAX)) return S_MAX;
    if (w < longint'(S_MIN)) return S_MIN;
    return w[31:0];
  endfunction

  // small values for duplicates, a few extremes, otherwise anything
  function automatic logic signed [31:0] pick_value();
    int unsigned        roll;
    logic signed [31:0] v;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      v = $signed(32'($urandom_range(0, 16))) - 32'sd8;
    end else if (roll < 45) begin
      case ($urandom_range(0, 5))
        0: v = S_MIN;
        1: v = S_MIN + 32'sd1;
        2: v = -32'sd1;
        3: v = 32'sd0;
        4: v = 32'sd1;
        default: v = S_MAX - 32'sd2;
      endcase
    end else begin
      v = $urandom;
    end
    // the top two values stay out of the table so a full table still refuses appends
    if (v > S_MAX - 32'sd2) v = S_MAX - 32'sd2;
    return v;
  endfunction

  function automatic req_t mk_req(logic [1:0] k, logic signed [31:0] v, logic signed [31:0] u);
    req_t r;
    r.kind  = k;
    r.value = v;
    r.upper = u;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t               r;
    int unsigned        roll;
    logic signed [31:0] lo_b;
    longint             w;
    roll    = $urandom_range(0, 99);
    r.upper = $urandom;
    if (roll < 30) begin
      r.kind  = KIND_LOAD;
      r.value = pick_value();
    end else if (roll < 65) begin
      r.kind = KIND_REPLACE;
      if ($urandom_range(0, 1)) begin
        // rising runs, as an increasing-subsequence scan would feed them
        w = longint'(run_val) + longint'($urandom_range(1, 5000));
        if (w > longint'(S_MAX - 32'sd2) || $urandom_range(0, 19) == 0) begin
          run_val = pick_value();
        end else begin
          run_val = w[31:0];
        end
        r.value = run_val;
      end else begin
        r.value = pick_value();
      end
    end else if (roll < 97) begin
      r.kind = KIND_COUNT;
      lo_b   = pick_value();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          r.value = lo_b;
          r.upper = clamp_word(longint'(lo_b) + longint'($urandom_range(0, 4000)));
        end
        4: begin
          // lower bound above upper bound
          r.upper = lo_b;
          r.value = clamp_word(longint'(lo_b) + longint'($urandom_range(1, 4000)));
        end
        5: begin
          r.value = S_MIN;
          r.upper = S_MAX;
        end
        6: begin
          r.value = lo_b;
          r.upper = S_MAX;
        end
        default: begin
          r.value = lo_b;
          r.upper = pick_value();
        end
      endcase
    end else begin
      r.kind  = KIND_UNUSED;
      r.value = $urandom;
    end
    return r;
  endfunction

  // offer one request, idling first at random; returns on the falling edge after acceptance
  task automatic send_request(input req_t r);
    while (!no_idle && $urandom_range(0, 99) < 38) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
    if (r.kind == KIND_LOAD) n_load++;
    else if (r.kind == KIND_REPLACE) n_replace++;
    else if (r.kind == KIND_COUNT) n_count++;
    else n_unused++;
  endtask

  // sender pause until every predicted result has come back
  task automatic wait_for_results();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    req_t        plan [$];
    int unsigned fill;
    int unsigned i;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty table, duplicates, extremes, every kind and its corner cases
    plan.push_back(mk_req(KIND_COUNT,   S_MIN,          S_MAX));
    plan.push_back(mk_req(KIND_REPLACE, 32'sd5,         $urandom));
    plan.push_back(mk_req(KIND_LOAD,    32'sd5,         $urandom));
    plan.push_back(mk_req(KIND_LOAD,    S_MIN,          $urandom));
    plan.push_back(mk_req(KIND_LOAD,    -32'sd1,        $urandom));
    plan.push_back(mk_req(KIND_LOAD,    32'sd0,         $urandom));
    plan.push_back(mk_req(KIND_REPLACE, 32'sd100,       $urandom));
    plan.push_back(mk_req(KIND_LOAD,    S_MAX,          $urandom));
    plan.push_back(mk_req(KIND_REPLACE, S_MAX,          $urandom));
    plan.push_back(mk_req(KIND_REPLACE, 32'sd5,         $urandom));
    plan.push_back(mk_req(KIND_REPLACE, 32'sd3,         $urandom));
    plan.push_back(mk_req(KIND_COUNT,   S_MIN,          S_MAX));
    plan.push_back(mk_req(KIND_COUNT,   32'sd10,        -32'sd10));
    plan.push_back(mk_req(KIND_COUNT,   32'sd5,         32'sd5));
    plan.push_back(mk_req(KIND_COUNT,   S_MAX,          S_MAX));
    plan.push_back(mk_req(KIND_COUNT,   S_MIN,          S_MIN));
    plan.push_back(mk_req(KIND_UNUSED,  $urandom,       $urandom));
    plan.push_back(mk_req(KIND_LOAD,    S_MIN,          $urandom));
    plan.push_back(mk_req(KIND_REPLACE, S_MIN,          $urandom));
    // overwrite the single top entry so the table no longer holds the maximum
    plan.push_back(mk_req(KIND_REPLACE, S_MAX - 32'sd1, $urandom));
    plan.push_back(mk_req(KIND_COUNT,   S_MAX,          S_MAX));
    plan.push_back(mk_req(KIND_COUNT,   -32'sd1,        32'sd0));
    plan.push_back(mk_req(KIND_COUNT,   S_MIN,          S_MAX - 32'sd1));
    foreach (plan[k]) send_request(plan[k]);
    wait_for_results();

    // random mix while the table grows
    for (i = 0; i < MIX_ITEMS; i++) begin
      if (i == 150) no_idle = 1'b1;
      if (i == 330) no_idle = 1'b0;
      if (i == 420) holds_asked++;
      if (i == 600) wait_for_results();
      send_request(random_request());
    end
    wait_for_results();

    // top the table up to capacity
    fill = CAPACITY - entries_held;
    for (i = 0; i < fill; i++) send_request(mk_req(KIND_LOAD, pick_value(), $urandom));

    // full table: refused load and appends, then a whole-range count
    send_request(mk_req(KIND_LOAD,    pick_value(),   $urandom));
    send_request(mk_req(KIND_REPLACE, S_MAX,          $urandom));
    send_request(mk_req(KIND_REPLACE, S_MAX - 32'sd1, $urandom));
    send_request(mk_req(KIND_COUNT,   S_MIN,          S_MAX));
    for (i = 0; i < FULL_ITEMS; i++) begin
      if (i == 100) holds_asked++;
      send_request(random_request());
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d loads, %0d replaces, %0d range counts, %0d unused kinds",
             n_load, n_replace, n_count, n_unused);
    $display("table ran up to %0d entries; %0d inserts refused while full",
             entries_held, refusals);
    if (mismatches == 0 && pending == 0) begin
      $display("sorted_table_replace_and_range_count_tb passed");
    end else begin
      $display("sorted_table_replace_and_range_count_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/strc_pkg.sv
rtl/core/strc_cell.sv
rtl/core/strc_tally.sv
rtl/core/sorted_table_replace_and_range_count.sv
rtl/core/strc_checker.sv
dv/sorted_table_replace_and_range_count_checker.sv
dv/sorted_table_replace_and_range_count_tb.sv
